>>> rtl/mbrtu_pkg.sv
// shared constants, types, crc helper and table presets for the read-holding responder
package mbrtu_pkg;
   localparam int FRAME_CAPACITY = 256;
   localparam int TABLE_WORDS    = 32;
   localparam int CNT_W          = $clog2(FRAME_CAPACITY + 1);
   localparam int IDX_W          = $clog2(TABLE_WORDS);

   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [1:0] CSR_STATION = 2'd0;
   localparam logic [1:0] CSR_GAP     = 2'd1;
   localparam logic [1:0] CSR_SILENCE = 2'd2;
   localparam logic [1:0] CSR_MAXQ    = 2'd3;

   localparam logic [15:0] TABLE_BASE = 16'h0038;
   localparam logic [7:0]  FUNC_READ  = 8'h03;
   localparam logic [5:0]  QTY_LIMIT  = 6'd32;
   localparam int          MIN_FRAME  = 8;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_HEAD  = 5'b00100,
      ST_WORD  = 5'b01000,
      ST_TAIL  = 5'b10000
   } state_type;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   // reset contents of the register table by word offset
   function automatic logic [15:0] preset_word(input logic [IDX_W-1:0] idx);
      logic [15:0] a;
      a = TABLE_BASE + 16'(idx);
      unique case (a)
         16'h003B: return 16'd100;
         16'h003C: return 16'd16;
         16'h003D: return 16'd4;
         16'h003F, 16'h0041, 16'h0044: return 16'd1;
         default: return 16'd0;
      endcase
   endfunction
endpackage

>>> rtl/mbrtu_ram.sv
// generic single-port-write ram with registered read
module mbrtu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/modbus_rtu_read_holding_responder.sv
// top level of the modbus rtu read-holding-registers responder
//  channel | ports                                   | direction
//  req     | req_valid/ready, operation,byte,index,val | in
//  rsp     | rsp_valid/ready, first,second,sv,last   | out
//  csr     | csr_write, csr_index, csr_data          | in
// a byte or a host write is taken on its own; every tick also passes through the
// frame check state. a tick that answers with q words goes through the check, the
// header, one word state visit per word, the tail and a final flush of the last
// byte, giving q+3 items (up to 35), each word read from the table ram ahead of
// its use through the registered read. after reset a clearing pass loads the
// preset words, with no transaction accepted. a stalled rsp holds the sequencer;
// req waits until the last response item has been taken.
module modbus_rtu_read_holding_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic [4:0]  req_table_index,
   input  logic [15:0] req_table_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_first_byte,
   output logic [7:0]  rsp_second_byte,
   output logic        rsp_second_valid,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   localparam int IW = mbrtu_pkg::IDX_W;
   localparam int CW = mbrtu_pkg::CNT_W;

   logic [7:0] station_ff, gap_ff, endsil_ff;
   logic [5:0] maxq_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= 8'd1; gap_ff <= 8'd10; endsil_ff <= 8'd5; maxq_ff <= 6'd32;
      end else if (csr_write) begin
         unique case (csr_index)
            mbrtu_pkg::CSR_STATION: station_ff <= csr_data;
            mbrtu_pkg::CSR_GAP:     gap_ff <= csr_data;
            mbrtu_pkg::CSR_SILENCE: endsil_ff <= csr_data;
            mbrtu_pkg::CSR_MAXQ:    maxq_ff <= csr_data[5:0];
         endcase
      end
   end

   // clearing pass
   logic [IW:0] clr_ff;
   logic clearing;
   assign clearing = !clr_ff[IW];
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (clearing) clr_ff <= clr_ff + 1'b1;
   end

   mbrtu_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff;
   logic [7:0] sil_ff;
   logic [7:0] hdr_ff [6];
   logic [7:0] tp_ff [2];
   logic [15:0] crc_ff;
   logic req_take;

   // response sequencer
   logic [15:0] addr_ff;     // word address being emitted
   logic [15:0] addr_in;
   logic [5:0]  qleft_ff;    // words still to emit
   logic [5:0]  q_ff;
   logic [1:0]  hstep_ff;
   logic [15:0] rcrc_ff;
   logic        pend_ff;     // one response byte held for pairing
   logic [7:0]  pbyte_ff;
   logic        rvalid_ff;

   // the idle flush must finish before the next transaction is taken
   logic idle_ok;
   assign idle_ok = !pend_ff && !rvalid_ff;

   assign req_ready = (state_ff == mbrtu_pkg::ST_IDLE) && !clearing && idle_ok;
   assign req_take = req_valid && req_ready;

   logic        ram_we;
   logic [IW-1:0] ram_wa, ram_ra;
   logic [15:0] ram_wd, ram_rd;
   logic        word_in_ff;  // read data belongs to table

   logic rsp_busy;
   assign rsp_busy = rvalid_ff && !rsp_ready;

   always_comb begin
      ram_we = 1'b0; ram_wa = req_table_index[IW-1:0]; ram_wd = req_table_value;
      if (clearing) begin
         ram_we = 1'b1; ram_wa = clr_ff[IW-1:0];
         ram_wd = mbrtu_pkg::preset_word(clr_ff[IW-1:0]);
      end else if (req_take && req_operation == mbrtu_pkg::OP_WRITE
                   && 32'(req_table_index) < mbrtu_pkg::TABLE_WORDS) begin
         ram_we = 1'b1;
      end
   end

   // the ram reads the address that addr_ff takes next
   always_comb begin
      addr_in = addr_ff;
      if (state_ff == mbrtu_pkg::ST_CHECK) addr_in = {hdr_ff[2], hdr_ff[3]};
      else if (!rsp_busy && state_ff == mbrtu_pkg::ST_WORD) addr_in = addr_ff + 1'b1;
   end
   logic [15:0] off;
   assign off = addr_in - mbrtu_pkg::TABLE_BASE;
   assign ram_ra = off[IW-1:0];

   mbrtu_ram #(.WIDTH(16), .DEPTH(mbrtu_pkg::TABLE_WORDS)) u_table (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd));

   logic [15:0] got;
   assign got = {tp_ff[1], tp_ff[0]};
   logic [15:0] qreq;
   assign qreq = {hdr_ff[4], hdr_ff[5]};
   logic [5:0] qc;
   always_comb begin
      qc = maxq_ff > mbrtu_pkg::QTY_LIMIT ? mbrtu_pkg::QTY_LIMIT : maxq_ff;
      if (qreq < 16'(qc)) qc = qreq[5:0];
   end

   // bytes produced this cycle by the sequencer (up to two)
   logic [7:0] b0, b1;
   logic       n2, emit, fin;
   logic [15:0] crc1, crc2;
   logic [15:0] wval;
   assign wval = word_in_ff ? ram_rd : 16'h0000;
   always_comb begin
      b0 = 8'h00; b1 = 8'h00; n2 = 1'b0; emit = 1'b0; fin = 1'b0;
      unique case (state_ff)
         mbrtu_pkg::ST_HEAD: begin
            emit = 1'b1;
            priority case (hstep_ff)
               2'd0: begin b0 = hdr_ff[0]; b1 = hdr_ff[1]; n2 = 1'b1; end
               default: begin b0 = {1'b0, q_ff, 1'b0}; end
            endcase
         end
         mbrtu_pkg::ST_WORD: begin emit = 1'b1; b0 = wval[15:8]; b1 = wval[7:0]; n2 = 1'b1; end
         mbrtu_pkg::ST_TAIL: begin emit = 1'b1; b0 = rcrc_ff[7:0]; b1 = rcrc_ff[15:8];
            n2 = 1'b1; fin = 1'b1; end
         default: ;
      endcase
      crc1 = mbrtu_pkg::crc_fold(rcrc_ff, b0);
      crc2 = n2 ? mbrtu_pkg::crc_fold(crc1, b1) : crc1;
   end

   logic rsp_load;
   assign rsp_load = !rsp_busy && ((emit && (pend_ff || n2))
                     || (state_ff == mbrtu_pkg::ST_IDLE && pend_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbrtu_pkg::ST_IDLE:
            if (req_take && req_operation == mbrtu_pkg::OP_TICK) state_in = mbrtu_pkg::ST_CHECK;
         mbrtu_pkg::ST_CHECK: begin
            state_in = mbrtu_pkg::ST_IDLE;
            if (32'(cnt_ff) >= mbrtu_pkg::MIN_FRAME && sil_ff > endsil_ff
                && hdr_ff[0] == station_ff && hdr_ff[1] == mbrtu_pkg::FUNC_READ
                && got == crc_ff) state_in = mbrtu_pkg::ST_HEAD;
         end
         mbrtu_pkg::ST_HEAD:
            if (!rsp_busy && hstep_ff != 2'd0)
               state_in = (q_ff == 6'd0) ? mbrtu_pkg::ST_TAIL : mbrtu_pkg::ST_WORD;
         mbrtu_pkg::ST_WORD:
            if (!rsp_busy && qleft_ff == 6'd1) state_in = mbrtu_pkg::ST_TAIL;
         mbrtu_pkg::ST_TAIL:
            if (!rsp_busy) state_in = mbrtu_pkg::ST_IDLE;
         default: state_in = mbrtu_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbrtu_pkg::ST_IDLE;
         cnt_ff <= '0; sil_ff <= '0; crc_ff <= 16'hFFFF;
         rvalid_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         if (!rsp_busy) state_ff <= state_in;
         if (rsp_load) rvalid_ff <= 1'b1;
         else if (rvalid_ff && rsp_ready) rvalid_ff <= 1'b0;
         if (req_take && req_operation == mbrtu_pkg::OP_BYTE) begin
            logic [CW-1:0] c;
            logic [15:0] cr;
            c = cnt_ff; cr = crc_ff;
            if (cnt_ff != '0 && sil_ff > gap_ff) begin c = '0; cr = 16'hFFFF; end
            if (32'(c) < mbrtu_pkg::FRAME_CAPACITY) begin
               if (c < CW'(6)) hdr_ff[c[2:0]] <= req_rx_byte;
               if (c >= CW'(2)) cr = mbrtu_pkg::crc_fold(cr, tp_ff[0]);
               tp_ff[0] <= tp_ff[1]; tp_ff[1] <= req_rx_byte;
               c = c + 1'b1;
               sil_ff <= '0;
            end
            cnt_ff <= c; crc_ff <= cr;
         end
         if (req_take && req_operation == mbrtu_pkg::OP_TICK && sil_ff != 8'hFF)
            sil_ff <= sil_ff + 1'b1;
         if (state_ff == mbrtu_pkg::ST_CHECK) begin
            if (32'(cnt_ff) >= mbrtu_pkg::MIN_FRAME && sil_ff > endsil_ff) begin
               cnt_ff <= '0; crc_ff <= 16'hFFFF;
            end
            hstep_ff <= 2'd0; rcrc_ff <= 16'hFFFF; q_ff <= qc; qleft_ff <= qc;
            pend_ff <= 1'b0;
         end
         addr_ff <= addr_in;
         word_in_ff <= (addr_in >= mbrtu_pkg::TABLE_BASE)
                       && (32'(off) < mbrtu_pkg::TABLE_WORDS);
         if (!rsp_busy && emit) begin
            if (state_ff == mbrtu_pkg::ST_HEAD) hstep_ff <= hstep_ff + 1'b1;
            if (state_ff == mbrtu_pkg::ST_WORD) qleft_ff <= qleft_ff - 1'b1;
            if (!fin) rcrc_ff <= crc2;
            // pair bytes: a held byte goes first
            if (pend_ff) begin
               rsp_first_byte <= pbyte_ff; rsp_second_byte <= b0;
               rsp_second_valid <= 1'b1; rsp_last <= 1'b0;
               if (n2) pbyte_ff <= b1;
               pend_ff <= n2;
            end else if (n2) begin
               rsp_first_byte <= b0; rsp_second_byte <= b1;
               rsp_second_valid <= 1'b1; rsp_last <= 1'b0;
            end else begin
               pbyte_ff <= b0; pend_ff <= 1'b1;
            end
         end
         // final single byte, emitted after the tail
         if (!rsp_busy && state_ff == mbrtu_pkg::ST_IDLE && pend_ff) begin
            rsp_first_byte <= pbyte_ff; rsp_second_byte <= 8'h00;
            rsp_second_valid <= 1'b0; rsp_last <= 1'b1;
            pend_ff <= 1'b0;
         end
      end
   end
   assign rsp_valid = rvalid_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped while stalled");
   assert property (@(posedge clock) disable iff (reset) clearing |-> !req_ready)
      else $error("transaction taken during clearing pass");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !rsp_second_valid)
      else $error("last item carries two bytes");
endmodule

>>> tb/sv/modbus_rtu_read_holding_responder_checker.sv
// checker: predicts responder output from observed req transactions and compares rsp
module modbus_rtu_read_holding_responder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic [4:0]  req_table_index,
   input  logic [15:0] req_table_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_first_byte,
   input  logic [7:0]  rsp_second_byte,
   input  logic        rsp_second_valid,
   input  logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IW = mbrtu_pkg::IDX_W;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic       second_valid;
      logic       last;
   } resp_item_type;

   resp_item_type pending_items[$];
   logic [7:0]  station, gap_ms, silence_limit;
   logic [5:0]  max_qty;
   int          frame_len;
   logic [7:0]  quiet_ms;
   logic [7:0]  header[6];
   logic [7:0]  tail[2];
   logic [15:0] frame_crc;
   logic [15:0] words[mbrtu_pkg::TABLE_WORDS];

   assign pending_count = pending_items.size();

   function automatic logic [15:0] fold_byte(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic logic [15:0] table_read(logic [15:0] addr);
      logic [15:0] off;
      off = addr - mbrtu_pkg::TABLE_BASE;
      if (addr >= mbrtu_pkg::TABLE_BASE && off < 16'(mbrtu_pkg::TABLE_WORDS))
         return words[off[IW-1:0]];
      return 16'h0000;
   endfunction

   task automatic build_response();
      logic [7:0]  bytes[$];
      logic [15:0] start, v, c;
      int          qty, n;
      resp_item_type it;
      if (header[0] != station || header[1] != mbrtu_pkg::FUNC_READ) return;
      if ({tail[1], tail[0]} != frame_crc) return;
      start = {header[2], header[3]};
      qty = int'({header[4], header[5]});
      if (qty > int'(max_qty)) qty = int'(max_qty);
      if (qty > int'(mbrtu_pkg::QTY_LIMIT)) qty = int'(mbrtu_pkg::QTY_LIMIT);
      bytes.push_back(header[0]);
      bytes.push_back(header[1]);
      bytes.push_back(8'(qty * 2));
      for (int i = 0; i < qty; i++) begin
         v = table_read(start + 16'(i));
         bytes.push_back(v[15:8]);
         bytes.push_back(v[7:0]);
      end
      c = 16'hFFFF;
      foreach (bytes[i]) c = fold_byte(c, bytes[i]);
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
      n = bytes.size();
      for (int p = 0; p < n; p += 2) begin
         it.first = bytes[p];
         it.second_valid = (p + 1 < n);
         it.second = it.second_valid ? bytes[p + 1] : 8'h00;
         it.last = (p + 2 >= n);
         pending_items.push_back(it);
      end
   endtask

   task automatic accept_byte(logic [7:0] b);
      if (frame_len > 0 && quiet_ms > gap_ms) begin
         frame_len = 0;
         frame_crc = 16'hFFFF;
      end
      if (frame_len >= mbrtu_pkg::FRAME_CAPACITY) return;
      if (frame_len < 6) header[3'(frame_len)] = b;
      if (frame_len >= 2) frame_crc = fold_byte(frame_crc, tail[0]);
      tail[0] = tail[1];
      tail[1] = b;
      frame_len++;
      quiet_ms = 8'd0;
   endtask

   always @(posedge clock) begin
      resp_item_type exp_item;
      if (reset) begin
         station = 8'd1; gap_ms = 8'd10; silence_limit = 8'd5; max_qty = 6'd32;
         frame_len = 0; frame_crc = 16'hFFFF; quiet_ms = 8'd0;
         header = '{default: 8'h00}; tail = '{default: 8'h00};
         for (int i = 0; i < mbrtu_pkg::TABLE_WORDS; i++)
            words[i] = mbrtu_pkg::preset_word(IW'(i));
         pending_items.delete();
         fail_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               mbrtu_pkg::CSR_STATION: station = csr_data;
               mbrtu_pkg::CSR_GAP:     gap_ms = csr_data;
               mbrtu_pkg::CSR_SILENCE: silence_limit = csr_data;
               mbrtu_pkg::CSR_MAXQ:    max_qty = csr_data[5:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_items.size() == 0) begin
               $display("%0t: unexpected response first=%h second=%h sv=%b last=%b",
                        $time, rsp_first_byte, rsp_second_byte, rsp_second_valid, rsp_last);
               fail_count++;
            end else begin
               exp_item = pending_items.pop_front();
               if (exp_item.first !== rsp_first_byte) begin
                  $display("%0t: first_byte expected %h actual %h", $time, exp_item.first,
                           rsp_first_byte);
                  fail_count++;
               end
               if (exp_item.second !== rsp_second_byte) begin
                  $display("%0t: second_byte expected %h actual %h", $time,
                           exp_item.second, rsp_second_byte);
                  fail_count++;
               end
               if (exp_item.second_valid !== rsp_second_valid) begin
                  $display("%0t: second_valid expected %b actual %b", $time,
                           exp_item.second_valid, rsp_second_valid);
                  fail_count++;
               end
               if (exp_item.last !== rsp_last) begin
                  $display("%0t: last expected %b actual %b", $time, exp_item.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_operation)
               mbrtu_pkg::OP_BYTE: accept_byte(req_rx_byte);
               mbrtu_pkg::OP_TICK: begin
                  if (quiet_ms != 8'hFF) quiet_ms++;
                  if (frame_len >= mbrtu_pkg::MIN_FRAME && quiet_ms > silence_limit) begin
                     build_response();
                     frame_len = 0;
                     frame_crc = 16'hFFFF;
                  end
               end
               mbrtu_pkg::OP_WRITE:
                  if (32'(req_table_index) < mbrtu_pkg::TABLE_WORDS)
                     words[req_table_index] = req_table_value;
               default: ;
            endcase
         end
      end
   end
endmodule

>>> tb/sv/modbus_rtu_read_holding_responder_tb.sv
// testbench top: clock, reset, stimulus and verdict for the read-holding responder
module modbus_rtu_read_holding_responder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = mbrtu_pkg::OP_TICK;
   logic [7:0]  req_rx_byte = 8'h00;
   logic [4:0]  req_table_index = 5'd0;
   logic [15:0] req_table_value = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_first_byte, rsp_second_byte;
   logic        rsp_second_valid, rsp_last;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = mbrtu_pkg::CSR_STATION;
   logic [7:0]  csr_data = 8'h00;
   int          fail_count, pending_count;
   int          cycle_count = 0;
   int          item_count = 0;
   bit          stim_done = 1'b0;
   bit          rsp_stall_en = 1'b1;
   logic [7:0]  station_now = 8'd1;

   localparam int CYCLE_LIMIT = 2000000;

   always #5 clock = ~clock;

   modbus_rtu_read_holding_responder DUT (.*);

   modbus_rtu_read_holding_responder_checker checker_inst (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("modbus_rtu_read_holding_responder verification failed");
         $finish;
      end
   end

   // receiver: random stall per result
   initial begin
      int w;
      @(negedge clock);
      forever begin
         w = rsp_stall_en ? $urandom_range(0, 4) : 0;
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // valid stays high after acceptance until the next falling edge
   task automatic send_item(logic [1:0] op, logic [7:0] b, logic [4:0] idx, logic [15:0] val);
      int w;
      w = $urandom_range(0, 4);
      @(negedge clock);
      if (w > 0) begin
         req_valid <= 1'b0;
         repeat (w) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_rx_byte <= b;
      req_table_index <= idx;
      req_table_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_count++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      wait_drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == mbrtu_pkg::CSR_STATION) station_now = val;
   endtask

   task automatic tick(int n);
      for (int i = 0; i < n; i++)
         send_item(mbrtu_pkg::OP_TICK, 8'($urandom), 5'($urandom), 16'($urandom));
   endtask

   // sends a frame with a correct or corrupted crc; end_frame supplies the silence that ends it
   task automatic send_request(logic [7:0] id, logic [7:0] func, logic [15:0] start,
                               logic [15:0] qty, bit bad_crc, int extra);
      logic [7:0]  fr[$];
      logic [15:0] c;
      fr = '{id, func, start[15:8], start[7:0], qty[15:8], qty[7:0]};
      for (int i = 0; i < extra; i++) fr.push_back(8'($urandom));
      c = 16'hFFFF;
      foreach (fr[i]) c = mbrtu_pkg::crc_fold(c, fr[i]);
      if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      foreach (fr[i]) send_item(mbrtu_pkg::OP_BYTE, fr[i], 5'($urandom), 16'($urandom));
   endtask

   task automatic end_frame(int limit);
      tick(limit + 1 + $urandom_range(0, 1));
   endtask

   initial begin
      int sel;
      int base;
      logic [7:0] sil;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      // directed part
      send_request(8'd1, mbrtu_pkg::FUNC_READ, 16'h0038, 16'd32, 0, 0); end_frame(5);
      send_request(8'd1, mbrtu_pkg::FUNC_READ, 16'h0050, 16'd0, 0, 0); end_frame(5);
      send_request(8'd1, mbrtu_pkg::FUNC_READ, 16'hFFFF, 16'hFFFF, 0, 0); end_frame(5);
      send_request(8'd1, mbrtu_pkg::FUNC_READ, 16'h0038, 16'd4, 1, 0); end_frame(5);
      send_item(mbrtu_pkg::OP_WRITE, 8'h00, 5'd0, 16'hFFFF);
      send_item(mbrtu_pkg::OP_WRITE, 8'hFF, 5'd31, 16'h0000);
      send_item(2'd3, 8'hFF, 5'd31, 16'hFFFF);
      send_request(8'd1, mbrtu_pkg::FUNC_READ, 16'h0037, 16'd3, 0, 0); end_frame(5);
      write_csr(mbrtu_pkg::CSR_MAXQ, 8'd3);
      write_csr(mbrtu_pkg::CSR_STATION, 8'hFF);
      write_csr(mbrtu_pkg::CSR_SILENCE, 8'd0);
      write_csr(mbrtu_pkg::CSR_GAP, 8'd0);
      send_request(8'hFF, mbrtu_pkg::FUNC_READ, 16'h0055, 16'd10, 0, 3); end_frame(0);
      // frame overflow, then silence saturating without ending the frame
      write_csr(mbrtu_pkg::CSR_GAP, 8'd255);
      write_csr(mbrtu_pkg::CSR_SILENCE, 8'd255);
      for (int i = 0; i < 257; i++)
         send_item(mbrtu_pkg::OP_BYTE, 8'($urandom), 5'd0, 16'd0);
      tick(258);
      write_csr(mbrtu_pkg::CSR_SILENCE, 8'd0);
      tick(1);
      // pause until all output drained
      wait_drain();
      write_csr(mbrtu_pkg::CSR_MAXQ, 8'd0);
      write_csr(mbrtu_pkg::CSR_SILENCE, 8'd3);
      write_csr(mbrtu_pkg::CSR_GAP, 8'd6);
      send_request(8'hFF, mbrtu_pkg::FUNC_READ, 16'h0038, 16'd5, 0, 0); end_frame(3);
      // random part
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(mbrtu_pkg::CSR_STATION, 8'($urandom));
         write_csr(mbrtu_pkg::CSR_GAP, 8'($urandom_range(2, 12)));
         sil = 8'($urandom_range(0, 6));
         write_csr(mbrtu_pkg::CSR_SILENCE, sil);
         write_csr(mbrtu_pkg::CSR_MAXQ, 8'($urandom_range(0, 32)));
         rsp_stall_en = (ph != 2);
         base = item_count;
         while (item_count < base + 10) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
               send_request(($urandom_range(0, 7) == 0) ? 8'($urandom) : station_now,
                            ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                        : mbrtu_pkg::FUNC_READ,
                            16'h0030 + 16'($urandom_range(0, 48)),
                            16'($urandom_range(0, 40)), $urandom_range(0, 7) == 0,
                            ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0);
               end_frame(int'(sil));
            end else if (sel < 8) begin
               send_item(mbrtu_pkg::OP_WRITE, 8'($urandom), 5'($urandom), 16'($urandom));
            end else if (sel < 9) begin
               send_item(mbrtu_pkg::OP_BYTE, 8'($urandom), 5'($urandom), 16'($urandom));
               tick($urandom_range(0, 14));
            end else begin
               send_item(2'($urandom), 8'($urandom), 5'($urandom), 16'($urandom));
            end
         end
      end
      stim_done = 1'b1;
      wait_drain();
      if (fail_count == 0) begin
         $display("modbus_rtu_read_holding_responder verification clean");
      end else begin
         $display("modbus_rtu_read_holding_responder verification failed");
      end
      $finish;
   end
endmodule
